// ----- rtl/core/raw_pixel_row_packer_core_defines.svh -----
// Assertion macros shared by the raw pixel row packer RTL.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef RAW_PIXEL_ROW_PACKER_CORE_DEFINES_SVH
`define RAW_PIXEL_ROW_PACKER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define RPP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("raw pixel row packer check failed");
`define RPP_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("raw pixel row packer forbidden condition");
`else
`define RPP_ASSERT(lbl, prop)
`define RPP_ASSERT_NEVER(lbl, expr)
`endif

`endif

// ----- rtl/core/rpp_pkg.sv -----
// Package for the raw pixel row packer: payload types, format codes and limits.
// No dependencies.
`timescale 1ns / 1ps

package rpp_pkg;

  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned OFS_W      = 26;
  localparam int unsigned STRIDE_W   = 14;
  localparam int unsigned COLOFS_W   = 15;

  localparam logic [2:0] FMT_L8     = 3'd0;
  localparam logic [2:0] FMT_I4     = 3'd1;
  localparam logic [2:0] FMT_I1     = 3'd2;
  localparam logic [2:0] FMT_RGB888 = 3'd3;
  localparam logic [2:0] FMT_RGB565 = 3'd4;

  localparam logic [1:0] CFG_PIXEL_FORMAT = 2'd0;
  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd2;

  typedef struct packed {
    logic        frame_start;
    logic [23:0] pixel_value;
  } in_payload_t;

  typedef struct packed {
    logic             status;
    logic [7:0]       data_byte;
    logic [OFS_W-1:0] byte_offset;
    logic             row_end;
    logic             frame_done;
    logic             last_of_run;
  } out_payload_t;

  typedef struct packed {
    logic [2:0]       pixel_format;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
  } cfg_t;

  typedef struct packed {
    logic                status;
    logic [23:0]         bytes;
    logic [1:0]          n_last;
    logic [OFS_W-1:0]    row_base;
    logic [COLOFS_W-1:0] col_off;
    logic                row_end;
    logic                frame_done;
  } desc_t;

endpackage

// ----- rtl/core/raw_pixel_row_packer_core.sv -----
// Raw pixel row packer top level: input register s0, descriptor register s1 and
// output register. One pixel per cycle for gray8, gray4 and mono1 while out_stall
// is low; rgb565 and rgb888 stall the input while the single byte-wide output
// register sends their bytes. Synchronous active low reset clears counters and
// valid flags and sets the configuration to gray8, one by one pixel.
// Depends on rpp_pkg, rpp_cfg_regs, rpp_pack and rpp_emit.
`timescale 1ns / 1ps

module raw_pixel_row_packer_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  rpp_pkg::in_payload_t       in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output rpp_pkg::out_payload_t      out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [rpp_pkg::DIM_W-1:0]  cfg_data
);

  rpp_pkg::cfg_t        cfg;
  rpp_pkg::in_payload_t s0_r, s0_nxt;
  logic                 s0_v_r, s0_v_nxt;
  rpp_pkg::desc_t       desc;
  logic                 desc_emit, emit_ready, s0_adv, in_take;

  rpp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign s0_adv   = s0_v_r && emit_ready;
  assign in_stall = s0_v_r && !s0_adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s0_nxt   = in_take ? in_data : s0_r;
    s0_v_nxt = in_take ? 1'b1 : (s0_adv ? 1'b0 : s0_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else begin
      s0_v_r <= s0_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s0_r <= s0_nxt;
  end

  rpp_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .pix       (s0_r),
    .advance   (s0_adv),
    .desc      (desc),
    .desc_emit (desc_emit)
  );

  rpp_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .desc_in   (desc),
    .load      (s0_adv && desc_emit),
    .ready     (emit_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/core/rpp_cfg_regs.sv -----
// Configuration register file for the raw pixel row packer.
// Depends on rpp_pkg.
`timescale 1ns / 1ps

module rpp_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [rpp_pkg::DIM_W-1:0]  cfg_data,
  output rpp_pkg::cfg_t              cfg
);

  rpp_pkg::cfg_t cfg_r;
  rpp_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        rpp_pkg::CFG_PIXEL_FORMAT: cfg_nxt.pixel_format = cfg_data[2:0];
        rpp_pkg::CFG_IMAGE_WIDTH:  cfg_nxt.image_width  = cfg_data;
        rpp_pkg::CFG_IMAGE_HEIGHT: cfg_nxt.image_height = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_format <= rpp_pkg::FMT_L8;
      cfg_r.image_width  <= rpp_pkg::DIM_W'(1);
      cfg_r.image_height <= rpp_pkg::DIM_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- rtl/core/rpp_pack.sv -----
// Pixel packing stage: row and column counters, the partial byte buffer and
// the row base multiply. Depends on rpp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "raw_pixel_row_packer_core_defines.svh"

module rpp_pack (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rpp_pkg::cfg_t        cfg,
  input  rpp_pkg::in_payload_t pix,
  input  logic                 advance,
  output rpp_pkg::desc_t       desc,
  output logic                 desc_emit
);

  localparam int unsigned DW = rpp_pkg::DIM_W;

  logic [DW-1:0] row_r, row_nxt;
  logic [DW-1:0] col_r, col_nxt;
  logic [7:0]    pbuf_r, pbuf_nxt;

  logic [DW-1:0] w, h;
  logic [DW-1:0] row_cur, col_cur;
  logic [7:0]    pbuf_cur, pbuf_new, i1_bit;
  logic          beyond, rend, fdone;
  logic [rpp_pkg::STRIDE_W-1:0] stride, w_ext;
  logic [rpp_pkg::COLOFS_W-1:0] col_off;
  logic [rpp_pkg::OFS_W-1:0]    prod_full;
  logic          emit_ok;
  logic [1:0]    n_last;
  logic [23:0]   bytes;

  always_comb begin
    if (cfg.image_width == '0) begin
      w = DW'(1);
    end else if (cfg.image_width > DW'(rpp_pkg::MAX_WIDTH)) begin
      w = DW'(rpp_pkg::MAX_WIDTH);
    end else begin
      w = cfg.image_width;
    end
    if (cfg.image_height == '0) begin
      h = DW'(1);
    end else if (cfg.image_height > DW'(rpp_pkg::MAX_HEIGHT)) begin
      h = DW'(rpp_pkg::MAX_HEIGHT);
    end else begin
      h = cfg.image_height;
    end
  end

  assign row_cur  = pix.frame_start ? '0 : row_r;
  assign col_cur  = pix.frame_start ? '0 : col_r;
  assign pbuf_cur = pix.frame_start ? '0 : pbuf_r;

  assign beyond = row_cur >= h;
  assign rend   = ({1'b0, col_cur} + 14'd1) >= {1'b0, w};
  assign fdone  = rend && (({1'b0, row_cur} + 14'd1) == {1'b0, h});
  assign w_ext  = {1'b0, w};
  assign i1_bit = pix.pixel_value[0] ? (8'h80 >> col_cur[2:0]) : 8'h00;

  always_comb begin
    stride   = w_ext;
    col_off  = {2'b00, col_cur};
    pbuf_new = pbuf_cur;
    emit_ok  = 1'b1;
    n_last   = 2'd0;
    bytes    = pix.pixel_value;
    unique case (cfg.pixel_format)
      rpp_pkg::FMT_I4: begin
        stride   = (w_ext + 14'd1) >> 1;
        col_off  = {3'b000, col_cur[DW-1:1]};
        pbuf_new = col_cur[0] ? {pbuf_cur[7:4], pix.pixel_value[3:0]}
                              : {pix.pixel_value[3:0], 4'h0};
        emit_ok  = col_cur[0] || rend;
        bytes    = {16'h0000, pbuf_new};
      end
      rpp_pkg::FMT_I1: begin
        stride   = (w_ext + 14'd7) >> 3;
        col_off  = {5'b00000, col_cur[DW-1:3]};
        pbuf_new = (col_cur[2:0] == 3'd0) ? i1_bit : (pbuf_cur | i1_bit);
        emit_ok  = (col_cur[2:0] == 3'd7) || rend;
        bytes    = {16'h0000, pbuf_new};
      end
      rpp_pkg::FMT_RGB888: begin
        stride  = w_ext + {w, 1'b0};
        col_off = {2'b00, col_cur} + {1'b0, col_cur, 1'b0};
        n_last  = 2'd2;
      end
      rpp_pkg::FMT_RGB565: begin
        stride  = {w, 1'b0};
        col_off = {1'b0, col_cur, 1'b0};
        n_last  = 2'd1;
      end
      default: begin
      end
    endcase
  end

  assign prod_full = rpp_pkg::OFS_W'(row_cur) * rpp_pkg::OFS_W'(stride);

  always_comb begin
    desc.status     = 1'b0;
    desc.bytes      = bytes;
    desc.n_last     = n_last;
    desc.row_base   = prod_full;
    desc.col_off    = col_off;
    desc.row_end    = rend;
    desc.frame_done = fdone;
    desc_emit       = emit_ok;
    if (beyond) begin
      desc.status     = 1'b1;
      desc.bytes      = '0;
      desc.n_last     = 2'd0;
      desc.row_base   = '0;
      desc.col_off    = '0;
      desc.row_end    = 1'b0;
      desc.frame_done = 1'b0;
      desc_emit       = 1'b1;
    end
  end

  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    pbuf_nxt = pbuf_r;
    if (advance) begin
      row_nxt  = row_cur;
      col_nxt  = col_cur;
      pbuf_nxt = pbuf_cur;
      if (!beyond) begin
        if (rend) begin
          row_nxt  = row_cur + DW'(1);
          col_nxt  = '0;
          pbuf_nxt = '0;
        end else begin
          col_nxt  = col_cur + DW'(1);
          pbuf_nxt = pbuf_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      pbuf_r <= '0;
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      pbuf_r <= pbuf_nxt;
    end
  end

  `RPP_ASSERT(a_row_bounded, row_r <= DW'(rpp_pkg::MAX_HEIGHT))
  `RPP_ASSERT(a_col_bounded, col_r < DW'(rpp_pkg::MAX_WIDTH))

endmodule

// ----- rtl/core/rpp_emit.sv -----
// Result stage: holds one packed pixel descriptor and sends its bytes one
// transaction at a time through the output register. Depends on rpp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "raw_pixel_row_packer_core_defines.svh"

module rpp_emit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rpp_pkg::desc_t        desc_in,
  input  logic                  load,
  output logic                  ready,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rpp_pkg::out_payload_t out_data
);

  rpp_pkg::desc_t        s1_r, s1_nxt;
  logic                  s1_v_r, s1_v_nxt;
  logic [1:0]            idx_r, idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  rpp_pkg::out_payload_t out_r, out_nxt;

  logic out_free, take, last_byte;
  logic [7:0] sel_byte;

  assign out_free  = !out_valid_r || !out_stall;
  assign take      = out_free && s1_v_r;
  assign last_byte = idx_r == s1_r.n_last;
  assign ready     = !s1_v_r || (take && last_byte);

  always_comb begin
    unique case (idx_r)
      2'd0:    sel_byte = s1_r.bytes[7:0];
      2'd1:    sel_byte = s1_r.bytes[15:8];
      2'd2:    sel_byte = s1_r.bytes[23:16];
      default: sel_byte = 8'h00;
    endcase
  end

  always_comb begin
    out_nxt.status      = s1_r.status;
    out_nxt.data_byte   = sel_byte;
    out_nxt.byte_offset = s1_r.row_base + rpp_pkg::OFS_W'(s1_r.col_off)
                          + rpp_pkg::OFS_W'(idx_r);
    out_nxt.row_end     = s1_r.row_end && last_byte;
    out_nxt.frame_done  = s1_r.frame_done && last_byte;
    out_nxt.last_of_run = last_byte;

    out_valid_nxt = out_free ? s1_v_r : out_valid_r;
    idx_nxt       = idx_r;
    if (take) begin
      idx_nxt = last_byte ? 2'd0 : idx_r + 2'd1;
    end
    s1_v_nxt = s1_v_r;
    if (load) begin
      s1_v_nxt = 1'b1;
    end else if (take && last_byte) begin
      s1_v_nxt = 1'b0;
    end
    s1_nxt = load ? desc_in : s1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    if (take) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `RPP_ASSERT(a_idx_in_range, s1_v_r |-> idx_r <= s1_r.n_last)
  `RPP_ASSERT(a_last_marked, (take && last_byte) |=> out_valid_r && out_r.last_of_run)
  `RPP_ASSERT_NEVER(a_err_clean, out_valid_r && out_r.status && (out_r.byte_offset != '0))

endmodule

// ----- sim/raw_pixel_row_packer_core_tb.sv -----
// Self-checking testbench for raw_pixel_row_packer_core: a directed table followed by
// random frames, each output byte checked against a table entry or the packer model.
// Depends on rpp_pkg and the packer RTL.
`timescale 1ns / 1ps

module raw_pixel_row_packer_core_tb;

  localparam int          CLK_PERIOD   = 20;
  localparam int          RESET_CYCLES = 11;
  localparam int          DRAIN_CYCLES = 10;
  localparam int          RANDOM_ITEMS = 96;
  localparam int          MAX_FRAME    = 16;
  localparam longint      TIMEOUT_NS   = 5_000_000;
  localparam logic [1:0]  CFG_UNUSED   = 2'd3;
  localparam logic [2:0]  FMT_UNKNOWN  = 3'd7;

  localparam rpp_pkg::out_payload_t NO_BYTE = '0;
  localparam rpp_pkg::out_payload_t REFUSED =
    '{status: 1'b1, last_of_run: 1'b1, default: '0};

  typedef enum bit {STEP_REG, STEP_PIXEL} step_kind_t;

  typedef struct {
    step_kind_t            kind;
    logic [1:0]            reg_idx;
    logic [12:0]           reg_val;
    logic                  frame_start;
    logic [23:0]           pixel;
    bit                    known;
    rpp_pkg::out_payload_t want;
  } dir_step_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  rpp_pkg::in_payload_t  in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  rpp_pkg::out_payload_t out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_index = '0;
  logic [12:0]           cfg_data = '0;

  logic [2:0]    fmt_reg;
  logic [12:0]   width_reg;
  logic [12:0]   height_reg;
  int unsigned   row_cnt;
  int unsigned   col_cnt;
  logic [7:0]    pack_byte;

  rpp_pkg::out_payload_t expected_bytes[$];
  int            mismatches = 0;
  int unsigned   cycle_cnt = 0;
  logic          calm;

  dir_step_t directed [0:39] = '{
    '{STEP_PIXEL, rpp_pkg::CFG_PIXEL_FORMAT, 13'd0, 1'b1, 24'hFFFFFF, 1'b1,
      '{1'b0, 8'hFF, 26'd0, 1'b1, 1'b1, 1'b1}},
    '{STEP_PIXEL, rpp_pkg::CFG_PIXEL_FORMAT, 13'd0, 1'b0, 24'h123456, 1'b1, REFUSED},
    '{STEP_PIXEL, rpp_pkg::CFG_PIXEL_FORMAT, 13'd0, 1'b1, 24'h000000, 1'b1,
      '{1'b0, 8'h00, 26'd0, 1'b1, 1'b1, 1'b1}},
    '{STEP_REG, rpp_pkg::CFG_PIXEL_FORMAT, 13'(rpp_pkg::FMT_RGB888), 1'b0, 24'h0, 1'b0,
      NO_BYTE},
    '{STEP_REG, rpp_pkg::CFG_IMAGE_WIDTH, 13'd2, 1'b0, 24'h0, 1'b0, NO_BYTE},
    '{STEP_REG, rpp_pkg::CFG_IMAGE_HEIGHT, 13'd2, 1'b0, 24'h0, 1'b0, NO_BYTE},
    '{STEP_PIXEL, rpp_pkg::CFG_PIXEL_FORMAT, 13'd0, 1'b1, 24'h0A0B0C, 1'b0, NO_BYTE},
    '{STEP_PIXEL, rpp_pkg::CFG_PIXEL_FORMAT, 13'd0, 1'b0, 24'hFFFFFF, 1'b0, NO_BYTE},
    '{STEP_PIXEL, rpp_pkg::CFG_PIXEL_FORMAT, 13'd0, 1'b0, 24'h000000, 1'b0, NO_BYTE},
    '{STEP_PIXEL, rpp_pkg::CFG_PIXEL_FORMAT, 13'd0, 1'b0, 24'h5A5AA5, 1'b0, NO_BYTE},
    '{STEP_PIXEL, rpp_pkg::CFG_PIXEL_FORMAT, 13'd0, 1'b0, 24'h777777, 1'b1, REFUSED},
    '{STEP_REG, rpp_pkg::CFG_PIXEL_FORMAT, 13'(rpp_pkg::FMT_I4), 1'b0, 24'h0, 1'b0,
      NO_BYTE},
    '{STEP_REG, rpp_pkg::CFG_IMAGE_WIDTH, 13'd3, 1'b0, 24'h0, 1'b0, NO_BYTE},
    '{STEP_REG, rpp_pkg::CFG_IMAGE_HEIGHT, 13'd1, 1'b0, 24'h0, 1'b0, NO_BYTE},
    '{STEP_PIXEL, rpp_pkg::CFG_PIXEL_FORMAT, 13'd0, 1'b1, 24'h00000F, 1'b0, NO_BYTE},
    '{STEP_PIXEL, rpp_pkg::CFG_PIXEL_FORMAT, 13'd0, 1'b0, 24'hFFFFF0, 1'b0, NO_BYTE},
    '{STEP_PIXEL, rpp_pkg::CFG_PIXEL_FORMAT, 13'd0, 1'b0, 24'h000003, 1'b0, NO_BYTE},
    '{STEP_REG, rpp_pkg::CFG_PIXEL_FORMAT, 13'(rpp_pkg::FMT_I1), 1'b0, 24'h0, 1'b0,
      NO_BYTE},
    '{STEP_REG, rpp_pkg::CFG_IMAGE_WIDTH, 13'd9, 1'b0, 24'h0, 1'b0, NO_BYTE},
    '{STEP_PIXEL, rpp_pkg::CFG_PIXEL_FORMAT, 13'd0, 1'b1, 24'h000001, 1'b0, NO_BYTE},
    '{STEP_PIXEL, rpp_pkg::CFG_PIXEL_FORMAT, 13'd0, 1'b0, 24'hFFFFFE, 1'b0, NO_BYTE},
    '{STEP_PIXEL, rpp_pkg::CFG_PIXEL_FORMAT, 13'd0, 1'b0, 24'h000001, 1'b0, NO_BYTE},
    '{STEP_PIXEL, rpp_pkg::CFG_PIXEL_FORMAT, 13'd0, 1'b0, 24'h000001, 1'b0, NO_BYTE},
    '{STEP_PIXEL, rpp_pkg::CFG_PIXEL_FORMAT, 13'd0, 1'b0, 24'hFFFFFE, 1'b0, NO_BYTE},
    '{STEP_PIXEL, rpp_pkg::CFG_PIXEL_FORMAT, 13'd0, 1'b0, 24'h000001, 1'b0, NO_BYTE},
    '{STEP_PIXEL, rpp_pkg::CFG_PIXEL_FORMAT, 13'd0, 1'b0, 24'hFFFFFF, 1'b0, NO_BYTE},
    '{STEP_PIXEL, rpp_pkg::CFG_PIXEL_FORMAT, 13'd0, 1'b0, 24'h000000, 1'b0, NO_BYTE},
    '{STEP_PIXEL, rpp_pkg::CFG_PIXEL_FORMAT, 13'd0, 1'b0, 24'h000001, 1'b0, NO_BYTE},
    '{STEP_REG, rpp_pkg::CFG_PIXEL_FORMAT, 13'(rpp_pkg::FMT_RGB565), 1'b0, 24'h0, 1'b0,
      NO_BYTE},
    '{STEP_REG, rpp_pkg::CFG_IMAGE_WIDTH, 13'd4096, 1'b0, 24'h0, 1'b0, NO_BYTE},
    '{STEP_REG, rpp_pkg::CFG_IMAGE_HEIGHT, 13'd4096, 1'b0, 24'h0, 1'b0, NO_BYTE},
    '{STEP_PIXEL, rpp_pkg::CFG_PIXEL_FORMAT, 13'd0, 1'b1, 24'hABCDEF, 1'b0, NO_BYTE},
    '{STEP_REG, rpp_pkg::CFG_IMAGE_WIDTH, 13'd0, 1'b0, 24'h0, 1'b0, NO_BYTE},
    '{STEP_PIXEL, rpp_pkg::CFG_PIXEL_FORMAT, 13'd0, 1'b0, 24'h123456, 1'b0, NO_BYTE},
    '{STEP_REG, CFG_UNUSED, 13'h1FFF, 1'b0, 24'h0, 1'b0, NO_BYTE},
    '{STEP_REG, rpp_pkg::CFG_PIXEL_FORMAT, 13'(FMT_UNKNOWN), 1'b0, 24'h0, 1'b0, NO_BYTE},
    '{STEP_REG, rpp_pkg::CFG_IMAGE_WIDTH, 13'h1FFF, 1'b0, 24'h0, 1'b0, NO_BYTE},
    '{STEP_REG, rpp_pkg::CFG_IMAGE_HEIGHT, 13'd0, 1'b0, 24'h0, 1'b0, NO_BYTE},
    '{STEP_PIXEL, rpp_pkg::CFG_PIXEL_FORMAT, 13'd0, 1'b1, 24'hFFFF80, 1'b1,
      '{1'b0, 8'h80, 26'd0, 1'b0, 1'b0, 1'b1}},
    '{STEP_PIXEL, rpp_pkg::CFG_PIXEL_FORMAT, 13'd0, 1'b0, 24'h000000, 1'b1,
      '{1'b0, 8'h00, 26'd1, 1'b0, 1'b0, 1'b1}}
  };

  raw_pixel_row_packer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  assign calm = (cycle_cnt % 1000) >= 600 && (cycle_cnt % 1000) < 900;

  function automatic int unsigned clamp_dim(logic [12:0] v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic void pack_pixel(input rpp_pkg::in_payload_t px,
                                     output rpp_pkg::out_payload_t res[3],
                                     output int n);
    logic [2:0]  fmt;
    int unsigned w, h, c, stride, base;
    logic [7:0]  bytes[3];
    logic [7:0]  bit_mask;
    bit          rend, fdone;
    n = 0;
    fmt = (fmt_reg <= rpp_pkg::FMT_RGB565) ? fmt_reg : rpp_pkg::FMT_L8;
    w = clamp_dim(width_reg, rpp_pkg::MAX_WIDTH);
    h = clamp_dim(height_reg, rpp_pkg::MAX_HEIGHT);
    if (px.frame_start) begin
      row_cnt = 0;
      col_cnt = 0;
      pack_byte = '0;
    end
    if (row_cnt >= h) begin
      res[0] = REFUSED;
      n = 1;
      return;
    end
    c = col_cnt;
    rend = (c + 1 >= w);
    fdone = rend && (row_cnt + 1 == h);
    case (fmt)
      rpp_pkg::FMT_I4:     stride = (w + 1) / 2;
      rpp_pkg::FMT_I1:     stride = (w + 7) / 8;
      rpp_pkg::FMT_RGB888: stride = w * 3;
      rpp_pkg::FMT_RGB565: stride = w * 2;
      default:             stride = w;
    endcase
    base = row_cnt * stride;
    bytes[0] = px.pixel_value[7:0];
    bytes[1] = px.pixel_value[15:8];
    bytes[2] = px.pixel_value[23:16];
    case (fmt)
      rpp_pkg::FMT_I4: begin
        if (c % 2 == 0) pack_byte = {px.pixel_value[3:0], 4'h0};
        else pack_byte[3:0] = px.pixel_value[3:0];
        if (c % 2 == 1 || rend) begin
          bytes[0] = pack_byte;
          n = 1;
          base += c / 2;
        end
      end
      rpp_pkg::FMT_I1: begin
        bit_mask = px.pixel_value[0] ? (8'h80 >> (c % 8)) : 8'h00;
        if (c % 8 == 0) pack_byte = bit_mask;
        else pack_byte = pack_byte | bit_mask;
        if (c % 8 == 7 || rend) begin
          bytes[0] = pack_byte;
          n = 1;
          base += c / 8;
        end
      end
      rpp_pkg::FMT_RGB888: begin
        n = 3;
        base += c * 3;
      end
      rpp_pkg::FMT_RGB565: begin
        n = 2;
        base += c * 2;
      end
      default: begin
        n = 1;
        base += c;
      end
    endcase
    for (int k = 0; k < n; k++) begin
      res[k] = '0;
      res[k].data_byte = bytes[k];
      res[k].byte_offset = rpp_pkg::OFS_W'(base + k);
      res[k].row_end = rend && (k == n - 1);
      res[k].frame_done = fdone && (k == n - 1);
      res[k].last_of_run = (k == n - 1);
    end
    if (rend) begin
      col_cnt = 0;
      row_cnt = row_cnt + 1;
      pack_byte = '0;
    end else begin
      col_cnt = (c + 1) % 8192;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t mismatch: %s", $realtime, msg);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      rpp_pkg::CFG_PIXEL_FORMAT: fmt_reg = val[2:0];
      rpp_pkg::CFG_IMAGE_WIDTH:  width_reg = val;
      rpp_pkg::CFG_IMAGE_HEIGHT: height_reg = val;
      default: ;
    endcase
  endtask

  task automatic send_pixel(input logic fs, input logic [23:0] pix, input bit known,
                            input rpp_pkg::out_payload_t want);
    rpp_pkg::in_payload_t  px;
    rpp_pkg::out_payload_t res[3];
    int                    n;
    px.frame_start = fs;
    px.pixel_value = pix;
    cfg_valid <= 1'b0;
    while (!calm && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (in_stall);
    pack_pixel(px, res, n);
    if (known) begin
      expected_bytes.push_back(want);
    end else begin
      for (int k = 0; k < n; k++) expected_bytes.push_back(res[k]);
    end
  endtask

  always @(posedge clk) begin : check_bytes
    rpp_pkg::out_payload_t want;
    cycle_cnt <= cycle_cnt + 1;
    out_stall <= !calm && ($urandom_range(99) < 16);
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction %h", out_data));
      end else begin
        want = expected_bytes.pop_front();
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", out_data.status, want.status));
        if (out_data.data_byte !== want.data_byte)
          report_mismatch($sformatf("data_byte got %h want %h", out_data.data_byte,
                                    want.data_byte));
        if (out_data.byte_offset !== want.byte_offset)
          report_mismatch($sformatf("byte_offset got %0d want %0d", out_data.byte_offset,
                                    want.byte_offset));
        if (out_data.row_end !== want.row_end)
          report_mismatch($sformatf("row_end got %0d want %0d", out_data.row_end,
                                    want.row_end));
        if (out_data.frame_done !== want.frame_done)
          report_mismatch($sformatf("frame_done got %0d want %0d", out_data.frame_done,
                                    want.frame_done));
        if (out_data.last_of_run !== want.last_of_run)
          report_mismatch($sformatf("last_of_run got %0d want %0d", out_data.last_of_run,
                                    want.last_of_run));
      end
    end
  end

  initial begin : stimulus
    bit          after_pixel;
    bit          fresh;
    int          sent;
    int unsigned npix;
    logic [2:0]  fmt;
    logic [12:0] w, h;
    fmt_reg = rpp_pkg::FMT_L8;
    width_reg = 13'd1;
    height_reg = 13'd1;
    row_cnt = 0;
    col_cnt = 0;
    pack_byte = '0;
    after_pixel = 1'b0;
    sent = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].kind == STEP_REG) begin
        if (after_pixel) settle();
        write_reg(directed[i].reg_idx, directed[i].reg_val);
        after_pixel = 1'b0;
      end else begin
        send_pixel(directed[i].frame_start, directed[i].pixel, directed[i].known,
                   directed[i].want);
        after_pixel = 1'b1;
      end
    end

    while (sent < RANDOM_ITEMS) begin
      settle();
      fmt = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
      case ($urandom_range(9))
        0:       w = 13'd0;
        1:       w = 13'd4096;
        2:       w = 13'h1FFF;
        3:       w = 13'($urandom_range(8190, 4097));
        default: w = 13'($urandom_range(12, 1));
      endcase
      case ($urandom_range(7))
        0:       h = 13'd0;
        1:       h = 13'h1FFF;
        default: h = 13'($urandom_range(3, 1));
      endcase
      write_reg(rpp_pkg::CFG_PIXEL_FORMAT, {10'($urandom_range(1023)), fmt});
      write_reg(rpp_pkg::CFG_IMAGE_WIDTH, w);
      write_reg(rpp_pkg::CFG_IMAGE_HEIGHT, h);
      if ($urandom_range(7) == 0) write_reg(CFG_UNUSED, 13'($urandom));
      npix = clamp_dim(w, rpp_pkg::MAX_WIDTH) * clamp_dim(h, rpp_pkg::MAX_HEIGHT);
      if (npix > MAX_FRAME) npix = MAX_FRAME;
      else npix += $urandom_range(2);
      if ($urandom_range(5) == 0) npix = $urandom_range(npix, 1);
      fresh = ($urandom_range(4) != 0);
      for (int i = 0; i < npix; i++) begin
        send_pixel((i == 0) ? fresh : ($urandom_range(24) == 0), 24'($urandom), 1'b0,
                   NO_BYTE);
        sent++;
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("raw_pixel_row_packer_core_tb: PASS");
    end else begin
      $display("raw_pixel_row_packer_core_tb: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("raw_pixel_row_packer_core_tb: FAIL");
    $finish;
  end

endmodule
